// ===== sv/cpcs_pkg.sv =====
// Shared types and constants for the circle particle collision step block.
// No dependencies; used by the top level.
package cpcs_pkg;

    typedef enum logic [1:0] {
        KIND_PAIR   = 2'd0,
        KIND_BORDER = 2'd1,
        KIND_INTEG  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int GRAV_W     = 16;
    localparam int TS_W       = 16;
    localparam int REST_W     = 9;
    localparam int REST_FRAC  = 8;
    localparam int DT_FRAC    = 16;
    localparam int SCALE_W    = 10;

    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESTITUTION = 2'd2;

    localparam logic [GRAV_W-1:0]  GRAV_RST = 16'd2537;
    localparam logic [TS_W-1:0]    TS_RST   = 16'd655;
    localparam logic [REST_W-1:0]  REST_RST = 9'd128;
    localparam logic [SCALE_W-1:0] SCALE_ONE = 10'd256;

endpackage

// ===== sv/cpcs_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; the caller keeps the sideband aligned with QUO_W stages of delay.
module cpcs_div #(
    parameter int NUM_W = 87,
    parameter int DEN_W = 59,
    parameter int QUO_W = 26
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    logic [NUM_W-1:0] r_rem [QUO_W-1];
    logic [DEN_W-1:0] r_den [QUO_W-1];
    logic [QUO_W-1:0] r_quo [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stg
        logic [NUM_W-1:0] rem_in;
        logic [NUM_W-1:0] sh_den;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [QUO_W-1:0] n_quo;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        always_comb begin
            sh_den = NUM_W'(den_in) << (QUO_W - 1 - k);
            ge     = rem_in >= sh_den;
            n_quo  = quo_in;
            n_quo[QUO_W-1-k] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= n_quo;
            end
        end

        if (k < QUO_W - 1) begin : g_keep
            logic [NUM_W-1:0] n_rem;
            always_comb begin
                n_rem = ge ? (rem_in - sh_den) : rem_in;
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

// ===== sv/circle_particle_collision_step_top.sv =====
// Top level of the circle particle collision step: contact tests, projection,
// integration and output register. Uses cpcs_pkg and cpcs_div.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------
//  in      | into      | i_in_valid / o_in_stall   | i_kind, i_a_*, i_b_*
//  out     | out of    | o_out_valid / i_out_stall | o_new_a_*, o_new_b_vel_*, o_impact
//  cfg     | into      | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One word enters per cycle unless a held output word stalls the pipe; a word passes
// eight arithmetic stages, COORD_BITS + 2 divider stages (one quotient bit each)
// and the output register. The divider sets the depth.
// Synchronous reset clears the valid bits and loads the register defaults.
// A stalled output word freezes the whole pipeline; no word is dropped or repeated.
module circle_particle_collision_step_top #(
    parameter int COORD_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_kind,
    input  logic signed [COORD_BITS-1:0]     i_a_pos_x,
    input  logic signed [COORD_BITS-1:0]     i_a_pos_y,
    input  logic signed [COORD_BITS-1:0]     i_a_vel_x,
    input  logic signed [COORD_BITS-1:0]     i_a_vel_y,
    input  logic [COORD_BITS-2:0]            i_a_radius,
    input  logic signed [COORD_BITS-1:0]     i_b_pos_x,
    input  logic signed [COORD_BITS-1:0]     i_b_pos_y,
    input  logic signed [COORD_BITS-1:0]     i_b_vel_x,
    input  logic signed [COORD_BITS-1:0]     i_b_vel_y,
    input  logic [COORD_BITS-2:0]            i_b_radius,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [COORD_BITS-1:0]     o_new_a_pos_x,
    output logic signed [COORD_BITS-1:0]     o_new_a_pos_y,
    output logic signed [COORD_BITS-1:0]     o_new_a_vel_x,
    output logic signed [COORD_BITS-1:0]     o_new_a_vel_y,
    output logic signed [COORD_BITS-1:0]     o_new_b_vel_x,
    output logic signed [COORD_BITS-1:0]     o_new_b_vel_y,
    output logic                             o_impact,
    input  logic                             i_cfg_we,
    input  logic [cpcs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cpcs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CW   = COORD_BITS;
    localparam int EW   = CW + 1;
    localparam int PW   = 2 * EW;
    localparam int DOTW = PW + 1;
    localparam int DDW  = 2 * CW + 2;
    localparam int LSW  = 2 * CW;
    localparam int PRW  = CW + cpcs_pkg::TS_W + 1;
    localparam int MW   = PRW - cpcs_pkg::DT_FRAC;
    localparam int SCW  = cpcs_pkg::SCALE_W;
    localparam int SDW  = PW + SCW;
    localparam int HLW  = SDW / 2;
    localparam int HHW  = SDW - HLW;
    localparam int NUMW = SDW + EW;
    localparam int NNW  = NUMW + 2;
    localparam int DENW = DDW + cpcs_pkg::REST_FRAC;
    localparam int DVW  = DENW + 1;
    localparam int QW   = CW + 2;
    localparam int SW   = CW + 3;
    localparam int NPRE = 8;
    localparam int LAT  = NPRE + QW;

    localparam logic signed [SW-1:0] SAT_HI = {{4{1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
    localparam logic [PRW-1:0] HALF_DT = PRW'(1) << (cpcs_pkg::DT_FRAC - 1);

    typedef struct packed {
        cpcs_pkg::t_kind        kind;
        logic signed [CW-1:0]   ax;
        logic signed [CW-1:0]   ay;
        logic signed [CW-1:0]   avx;
        logic signed [CW-1:0]   avy;
        logic signed [CW-1:0]   bvx;
        logic signed [CW-1:0]   bvy;
    } t_side;

    typedef struct packed {
        logic hit;
        logic tnx;
        logic tny;
    } t_res;

    typedef struct packed {
        t_side                  side;
        logic signed [EW-1:0]   dx, dy, rx, ry;
        logic signed [EW-1:0]   le_a, le_b, ri_a, ri_b;
        logic signed [EW-1:0]   to_a, to_b, bo_a, bo_b;
        logic signed [CW-1:0]   lim;
        logic signed [CW-1:0]   nvy;
    } t_s1;

    typedef struct packed {
        t_side                  side;
        logic signed [EW-1:0]   dx, dy;
        logic [PW-1:0]          sqx, sqy;
        logic signed [PW-1:0]   pdx, pdy;
        logic [LSW-1:0]         limsq;
        logic                   lim_neg;
        logic                   ovl;
        logic signed [PRW-1:0]  prx, pry;
        logic signed [CW-1:0]   nvy;
    } t_s2;

    typedef struct packed {
        t_side                  side;
        logic signed [EW-1:0]   dx, dy;
        logic [DDW-1:0]         dd;
        logic signed [DOTW-1:0] dot;
        logic [LSW-1:0]         limsq;
        logic                   lim_neg;
        logic                   ovl;
        logic [MW-1:0]          mx, my;
        logic                   sx, sy;
        logic signed [CW-1:0]   nvy;
    } t_s3;

    typedef struct packed {
        t_side          side;
        t_res           res;
        logic [PW-1:0]  dotm;
        logic [EW-1:0]  dxm, dym;
        logic [DENW-1:0] den;
        logic [SCW-1:0] scale;
    } t_s4;

    typedef struct packed {
        t_side           side;
        t_res            res;
        logic [SDW-1:0]  sdot;
        logic [EW-1:0]   dxm, dym;
        logic [DENW-1:0] den;
    } t_s5;

    typedef struct packed {
        t_side              side;
        t_res               res;
        logic [HLW+EW-1:0]  plx, ply;
        logic [HHW+EW-1:0]  phx, phy;
        logic [DENW-1:0]    den;
    } t_s6;

    typedef struct packed {
        t_side           side;
        t_res            res;
        logic [NUMW-1:0] numx, numy;
        logic [DENW-1:0] den;
    } t_s7;

    typedef struct packed {
        t_side          side;
        t_res           res;
        logic [NNW-1:0] nnx, nny;
        logic [DVW-1:0] dv;
    } t_s8;

    typedef struct packed {
        t_side side;
        t_res  res;
    } t_tail;

    function automatic logic signed [CW-1:0] satw(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return c[CW-1:0];
    endfunction

    logic [cpcs_pkg::GRAV_W-1:0] r_grav;
    logic [cpcs_pkg::TS_W-1:0]   r_ts;
    logic [cpcs_pkg::REST_W-1:0] r_rest;

    logic            en;
    logic [LAT-1:0]  r_vld;
    t_s1             n_s1, r_s1;
    t_s2             n_s2, r_s2;
    t_s3             n_s3, r_s3;
    t_s4             n_s4, r_s4;
    t_s5             n_s5, r_s5;
    t_s6             n_s6, r_s6;
    t_s7             n_s7, r_s7;
    t_s8             n_s8, r_s8;
    t_tail           r_tail [QW];
    logic [QW-1:0]   qx, qy;

    logic                  r_out_valid;
    logic signed [CW-1:0]  r_px, r_py, r_vax, r_vay, r_vbx, r_vby;
    logic                  r_imp;
    logic signed [CW-1:0]  n_px, n_py, n_vax, n_vay, n_vbx, n_vby;
    logic                  n_imp;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= cpcs_pkg::GRAV_RST;
            r_ts   <= cpcs_pkg::TS_RST;
            r_rest <= cpcs_pkg::REST_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cpcs_pkg::REG_GRAVITY:     r_grav <= i_cfg_data;
                cpcs_pkg::REG_TIME_STEP:   r_ts   <= i_cfg_data;
                cpcs_pkg::REG_RESTITUTION: r_rest <= i_cfg_data[cpcs_pkg::REST_W-1:0];
                default: ;
            endcase
        end
    end

    // advance the whole pipe unless the output word is held
    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    // stage 1: differences, box edges, gravity
    always_comb begin
        logic signed [EW-1:0] ax_e, ay_e, bx_e, by_e, avx_e, avy_e, bvx_e, bvy_e;
        logic signed [EW-1:0] ar_e, br_e;
        ax_e  = EW'(i_a_pos_x);
        ay_e  = EW'(i_a_pos_y);
        bx_e  = EW'(i_b_pos_x);
        by_e  = EW'(i_b_pos_y);
        avx_e = EW'(i_a_vel_x);
        avy_e = EW'(i_a_vel_y);
        bvx_e = EW'(i_b_vel_x);
        bvy_e = EW'(i_b_vel_y);
        ar_e  = {2'b00, i_a_radius};
        br_e  = {2'b00, i_b_radius};
        n_s1.side.kind = cpcs_pkg::t_kind'(i_kind);
        n_s1.side.ax   = i_a_pos_x;
        n_s1.side.ay   = i_a_pos_y;
        n_s1.side.avx  = i_a_vel_x;
        n_s1.side.avy  = i_a_vel_y;
        n_s1.side.bvx  = i_b_vel_x;
        n_s1.side.bvy  = i_b_vel_y;
        if (cpcs_pkg::t_kind'(i_kind) == cpcs_pkg::KIND_PAIR) begin
            n_s1.dx = ax_e - bx_e;
            n_s1.dy = ay_e - by_e;
            n_s1.rx = avx_e - bvx_e;
            n_s1.ry = avy_e - bvy_e;
        end else begin
            n_s1.dx = bx_e - ax_e;
            n_s1.dy = by_e - ay_e;
            n_s1.rx = avx_e;
            n_s1.ry = avy_e;
        end
        n_s1.le_a = ax_e - ar_e;
        n_s1.le_b = bx_e - br_e;
        n_s1.ri_a = ax_e + ar_e;
        n_s1.ri_b = bx_e + br_e;
        n_s1.to_a = ay_e - ar_e;
        n_s1.to_b = by_e - br_e;
        n_s1.bo_a = ay_e + ar_e;
        n_s1.bo_b = by_e + br_e;
        n_s1.lim  = $signed({1'b0, i_b_radius}) - $signed({1'b0, i_a_radius});
        n_s1.nvy  = satw(SW'(i_a_vel_y) + SW'(r_grav));
    end

    // stage 2: squares, dot terms, box overlap, time-step products
    always_comb begin
        logic signed [EW-1:0] lft, rgt, top, bot;
        lft = (r_s1.le_a > r_s1.le_b) ? r_s1.le_a : r_s1.le_b;
        rgt = (r_s1.ri_a < r_s1.ri_b) ? r_s1.ri_a : r_s1.ri_b;
        top = (r_s1.to_a > r_s1.to_b) ? r_s1.to_a : r_s1.to_b;
        bot = (r_s1.bo_a < r_s1.bo_b) ? r_s1.bo_a : r_s1.bo_b;
        n_s2.side    = r_s1.side;
        n_s2.dx      = r_s1.dx;
        n_s2.dy      = r_s1.dy;
        n_s2.sqx     = r_s1.dx * r_s1.dx;
        n_s2.sqy     = r_s1.dy * r_s1.dy;
        n_s2.pdx     = r_s1.rx * r_s1.dx;
        n_s2.pdy     = r_s1.ry * r_s1.dy;
        n_s2.limsq   = r_s1.lim * r_s1.lim;
        n_s2.lim_neg = r_s1.lim[CW-1];
        n_s2.ovl     = (lft < rgt) && (top < bot);
        n_s2.prx     = r_s1.side.avx * $signed({1'b0, r_ts});
        n_s2.pry     = r_s1.nvy * $signed({1'b0, r_ts});
        n_s2.nvy     = r_s1.nvy;
    end

    // stage 3: distance squared, dot product, rounded moves
    always_comb begin
        logic [PRW-1:0] ax_m, ay_m, rx_m, ry_m;
        ax_m = r_s2.prx[PRW-1] ? PRW'(-r_s2.prx) : PRW'(r_s2.prx);
        ay_m = r_s2.pry[PRW-1] ? PRW'(-r_s2.pry) : PRW'(r_s2.pry);
        rx_m = ax_m + HALF_DT;
        ry_m = ay_m + HALF_DT;
        n_s3.side    = r_s2.side;
        n_s3.dx      = r_s2.dx;
        n_s3.dy      = r_s2.dy;
        n_s3.dd      = r_s2.sqx + r_s2.sqy;
        n_s3.dot     = DOTW'(r_s2.pdx) + DOTW'(r_s2.pdy);
        n_s3.limsq   = r_s2.limsq;
        n_s3.lim_neg = r_s2.lim_neg;
        n_s3.ovl     = r_s2.ovl;
        n_s3.mx      = rx_m[PRW-1:cpcs_pkg::DT_FRAC];
        n_s3.my      = ry_m[PRW-1:cpcs_pkg::DT_FRAC];
        n_s3.sx      = r_s2.prx[PRW-1];
        n_s3.sy      = r_s2.pry[PRW-1];
        n_s3.nvy     = r_s2.nvy;
    end

    // stage 4: contact decision, magnitudes, integrated position
    always_comb begin
        logic contact, outside, is_coll;
        logic signed [DOTW-1:0] dot_abs;
        outside = r_s3.lim_neg || (r_s3.dd > {2'b00, r_s3.limsq});
        contact = (r_s3.side.kind == cpcs_pkg::KIND_PAIR) ? r_s3.ovl : outside;
        is_coll = (r_s3.side.kind == cpcs_pkg::KIND_PAIR) ||
                  (r_s3.side.kind == cpcs_pkg::KIND_BORDER);
        dot_abs = r_s3.dot[DOTW-1] ? -r_s3.dot : r_s3.dot;
        n_s4.side    = r_s3.side;
        n_s4.res.hit = is_coll && contact && (r_s3.dd != '0) && r_s3.dot[DOTW-1];
        // the dot is negative on a hit, so t is negative where the distance is not
        n_s4.res.tnx = !r_s3.dx[EW-1];
        n_s4.res.tny = !r_s3.dy[EW-1];
        n_s4.dotm    = dot_abs[PW-1:0];
        n_s4.dxm     = r_s3.dx[EW-1] ? EW'(-r_s3.dx) : EW'(r_s3.dx);
        n_s4.dym     = r_s3.dy[EW-1] ? EW'(-r_s3.dy) : EW'(r_s3.dy);
        n_s4.den     = {r_s3.dd, {cpcs_pkg::REST_FRAC{1'b0}}};
        n_s4.scale   = (r_s3.side.kind == cpcs_pkg::KIND_PAIR) ? cpcs_pkg::SCALE_ONE
                     : cpcs_pkg::SCALE_ONE + SCW'(r_rest);
        if (r_s3.side.kind == cpcs_pkg::KIND_INTEG) begin
            n_s4.side.ax  = satw(r_s3.sx ? SW'(r_s3.side.ax) - SW'(r_s3.mx)
                                         : SW'(r_s3.side.ax) + SW'(r_s3.mx));
            n_s4.side.ay  = satw(r_s3.sy ? SW'(r_s3.side.ay) - SW'(r_s3.my)
                                         : SW'(r_s3.side.ay) + SW'(r_s3.my));
            n_s4.side.avy = r_s3.nvy;
        end
    end

    // stage 5: scale the dot magnitude
    always_comb begin
        n_s5.side = r_s4.side;
        n_s5.res  = r_s4.res;
        n_s5.sdot = r_s4.dotm * r_s4.scale;
        n_s5.dxm  = r_s4.dxm;
        n_s5.dym  = r_s4.dym;
        n_s5.den  = r_s4.den;
    end

    // stage 6: split products against each distance component
    always_comb begin
        n_s6.side = r_s5.side;
        n_s6.res  = r_s5.res;
        n_s6.plx  = r_s5.sdot[HLW-1:0] * r_s5.dxm;
        n_s6.ply  = r_s5.sdot[HLW-1:0] * r_s5.dym;
        n_s6.phx  = r_s5.sdot[SDW-1:HLW] * r_s5.dxm;
        n_s6.phy  = r_s5.sdot[SDW-1:HLW] * r_s5.dym;
        n_s6.den  = r_s5.den;
    end

    // stage 7: join partial products
    always_comb begin
        n_s7.side = r_s6.side;
        n_s7.res  = r_s6.res;
        n_s7.numx = (NUMW'(r_s6.phx) << HLW) + NUMW'(r_s6.plx);
        n_s7.numy = (NUMW'(r_s6.phy) << HLW) + NUMW'(r_s6.ply);
        n_s7.den  = r_s6.den;
    end

    // stage 8: round to nearest by dividing 2n + d by 2d
    always_comb begin
        n_s8.side = r_s7.side;
        n_s8.res  = r_s7.res;
        n_s8.nnx  = (NNW'(r_s7.numx) << 1) + NNW'(r_s7.den);
        n_s8.nny  = (NNW'(r_s7.numy) << 1) + NNW'(r_s7.den);
        n_s8.dv   = {r_s7.den, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            r_s5 <= n_s5;
            r_s6 <= n_s6;
            r_s7 <= n_s7;
            r_s8 <= n_s8;
            r_tail[0] <= t_tail'{side: r_s8.side, res: r_s8.res};
            for (int i = 1; i < QW; i++) begin
                r_tail[i] <= r_tail[i-1];
            end
        end
    end

    cpcs_div #(.NUM_W(NNW), .DEN_W(DVW), .QUO_W(QW)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_s8.nnx),
        .i_den (r_s8.dv),
        .o_quo (qx)
    );

    cpcs_div #(.NUM_W(NNW), .DEN_W(DVW), .QUO_W(QW)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_s8.nny),
        .i_den (r_s8.dv),
        .o_quo (qy)
    );

    // apply the velocity change
    always_comb begin
        t_tail tl;
        logic signed [SW-1:0] avx_e, avy_e, bvx_e, bvy_e, tx, ty;
        tl    = r_tail[QW-1];
        avx_e = SW'(tl.side.avx);
        avy_e = SW'(tl.side.avy);
        bvx_e = SW'(tl.side.bvx);
        bvy_e = SW'(tl.side.bvy);
        tx    = {1'b0, qx};
        ty    = {1'b0, qy};
        n_px  = tl.side.ax;
        n_py  = tl.side.ay;
        n_vax = tl.side.avx;
        n_vay = tl.side.avy;
        n_vbx = tl.side.bvx;
        n_vby = tl.side.bvy;
        n_imp = tl.res.hit;
        if (tl.res.hit) begin
            n_vax = satw(tl.res.tnx ? avx_e + tx : avx_e - tx);
            n_vay = satw(tl.res.tny ? avy_e + ty : avy_e - ty);
            if (tl.side.kind == cpcs_pkg::KIND_PAIR) begin
                n_vbx = satw(tl.res.tnx ? bvx_e - tx : bvx_e + tx);
                n_vby = satw(tl.res.tny ? bvy_e - ty : bvy_e + ty);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px  <= n_px;
            r_py  <= n_py;
            r_vax <= n_vax;
            r_vay <= n_vay;
            r_vbx <= n_vbx;
            r_vby <= n_vby;
            r_imp <= n_imp;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_new_a_pos_x = r_px;
    assign o_new_a_pos_y = r_py;
    assign o_new_a_vel_x = r_vax;
    assign o_new_a_vel_y = r_vay;
    assign o_new_b_vel_x = r_vbx;
    assign o_new_b_vel_y = r_vby;
    assign o_impact      = r_imp;

endmodule

// ===== sv/cpcs_chk.sv =====
// Port-level checker for the circle particle collision step top level.
// Attached by the bind statement at the end; needs no package.
module cpcs_chk #(
    parameter int COORD_BITS = 24
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic signed [COORD_BITS-1:0] o_new_a_vel_x,
    input logic                         o_impact
);

    // a held word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_new_a_vel_x)
            && $stable(o_impact))
        else $error("output word changed while stalled");

    // input stall only comes from a held output word
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    // a draining output never blocks the input
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || !i_out_stall) && i_in_valid |-> !o_in_stall)
        else $error("input stalled while pipeline free to advance");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind circle_particle_collision_step_top cpcs_chk #(.COORD_BITS(COORD_BITS)) u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_new_a_vel_x (o_new_a_vel_x),
    .o_impact      (o_impact)
);
